### rtl/core/bilinear_table_interpolator_macros.svh
// Assertion macros for the bilinear table interpolator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BILINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define BTI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/bti_pkg.sv
// Shared types and constants for the bilinear table interpolator.
// No dependencies.
`default_nettype none
package bti_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 17;
    localparam int MAX_X_POINTS = 16;
    localparam int MAX_Y_POINTS = 16;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [1:0] ACT_WRITE_X = 2'd0;
    localparam logic [1:0] ACT_WRITE_Y = 2'd1;
    localparam logic [1:0] ACT_WRITE_G = 2'd2;
    localparam logic [1:0] ACT_EVAL    = 2'd3;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_CHK0,
        ST_CHKN,
        ST_SCAN,
        ST_DIV,
        ST_WGT,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIRST,
        OP_LAST,
        OP_SCAN,
        OP_DIV,
        OP_WGT,
        OP_MUL,
        OP_ACC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_NEXT
    } addr_sel_t;

    typedef struct packed {
        logic      axis;
        addr_sel_t addr_sel;
        dp_op_t    op;
    } cmd_t;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic scan_more;
        logic div_last;
        logic corner_last;
    } stat_t;

endpackage
`default_nettype wire

### rtl/core/bti_ctrl.sv
// Sequencer for the interpolator: interval search, division, corner blend.
// Depends on bti_pkg.
`default_nettype none
module bti_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    action,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire bti_pkg::stat_t stat,
    output bti_pkg::cmd_t      cmd
);

    bti_pkg::state_t state_reg, state_next;
    logic axis_reg, axis_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            bti_pkg::ST_IDLE:
            begin
                if (in_valid && action == bti_pkg::ACT_EVAL)
                begin
                    state_next = bti_pkg::ST_RD0;
                    axis_next  = 1'b0;
                end
            end
            bti_pkg::ST_RD0: state_next = bti_pkg::ST_CHK0;
            bti_pkg::ST_CHK0:
            begin
                if (stat.le_first)
                begin
                    state_next = axis_reg ? bti_pkg::ST_WGT : bti_pkg::ST_RD0;
                    axis_next  = 1'b1;
                end
                else
                begin
                    state_next = bti_pkg::ST_CHKN;
                end
            end
            bti_pkg::ST_CHKN:
            begin
                if (stat.ge_last)
                begin
                    state_next = axis_reg ? bti_pkg::ST_WGT : bti_pkg::ST_RD0;
                    axis_next  = 1'b1;
                end
                else
                begin
                    state_next = bti_pkg::ST_SCAN;
                end
            end
            bti_pkg::ST_SCAN:
            begin
                if (!stat.scan_more)
                    state_next = bti_pkg::ST_DIV;
            end
            bti_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = axis_reg ? bti_pkg::ST_WGT : bti_pkg::ST_RD0;
                    axis_next  = 1'b1;
                end
            end
            bti_pkg::ST_WGT: state_next = bti_pkg::ST_MUL;
            bti_pkg::ST_MUL: state_next = bti_pkg::ST_ACC;
            bti_pkg::ST_ACC:
            begin
                state_next = stat.corner_last ? bti_pkg::ST_DONE : bti_pkg::ST_WGT;
            end
            bti_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = bti_pkg::ST_IDLE;
            end
            default: state_next = bti_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.axis     = axis_reg;
        cmd.addr_sel = bti_pkg::ADDR_ZERO;
        cmd.op       = bti_pkg::OP_NONE;
        in_stall     = 1'b1;
        unique case (state_reg)
            bti_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && action == bti_pkg::ACT_EVAL)
                    cmd.op = bti_pkg::OP_LOAD;
            end
            bti_pkg::ST_RD0: cmd.addr_sel = bti_pkg::ADDR_ZERO;
            bti_pkg::ST_CHK0:
            begin
                cmd.op       = bti_pkg::OP_FIRST;
                cmd.addr_sel = bti_pkg::ADDR_LAST;
            end
            bti_pkg::ST_CHKN:
            begin
                cmd.op       = bti_pkg::OP_LAST;
                cmd.addr_sel = bti_pkg::ADDR_NEXT;
            end
            bti_pkg::ST_SCAN:
            begin
                cmd.op       = bti_pkg::OP_SCAN;
                cmd.addr_sel = bti_pkg::ADDR_NEXT;
            end
            bti_pkg::ST_DIV: cmd.op = bti_pkg::OP_DIV;
            bti_pkg::ST_WGT: cmd.op = bti_pkg::OP_WGT;
            bti_pkg::ST_MUL: cmd.op = bti_pkg::OP_MUL;
            bti_pkg::ST_ACC: cmd.op = bti_pkg::OP_ACC;
            bti_pkg::ST_DONE:
            begin
                if (out_free)
                    cmd.op = bti_pkg::OP_OUT;
            end
            default: cmd.op = bti_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == bti_pkg::ST_DONE && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bti_pkg::ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### rtl/core/bti_dp.sv
// Datapath: breakpoint and grid memories, search registers, restoring
// divider and blend accumulator. Depends on bti_pkg.
`default_nettype none
module bti_dp #(
    parameter int MAX_X = bti_pkg::MAX_X_POINTS,
    parameter int MAX_Y = bti_pkg::MAX_Y_POINTS
) (
    input  wire logic               clk,
    input  wire bti_pkg::cmd_t      cmd,
    input  wire logic               in_fire,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         row_index,
    input  wire logic [3:0]         col_index,
    input  wire logic signed [31:0] write_value,
    input  wire logic signed [31:0] query_x,
    input  wire logic signed [31:0] query_y,
    input  wire logic [4:0]         x_count,
    input  wire logic [4:0]         y_count,
    output bti_pkg::stat_t          stat,
    output logic signed [31:0]      interpolated
);

    localparam int MAXP = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
    localparam int KW   = $clog2(MAXP);
    localparam int NW   = $clog2(MAXP + 1);
    localparam int XAW  = $clog2(MAX_X);
    localparam int YAW  = $clog2(MAX_Y);
    localparam int GAW  = $clog2(MAX_X * MAX_Y);
    localparam int FW   = bti_pkg::FRAC_W;
    localparam int PW   = 2 * FW + 1 + bti_pkg::DATA_W;

    logic signed [31:0] xmem [MAX_X];
    logic signed [31:0] ymem [MAX_Y];
    logic signed [31:0] gmem [MAX_X * MAX_Y];
    logic signed [31:0] rdx_reg, rdy_reg, rdg_reg;

    logic signed [31:0] qx_reg, qy_reg, lo_reg, out_reg;
    logic [KW-1:0]      k_reg, i_reg, j_reg;
    logic [32:0]        rem_reg, den_reg;
    logic [3:0]         div_cnt_reg;
    logic [FW-1:0]      fx_reg, fy_reg;
    logic [1:0]         corner_reg;
    logic [2*FW-1:0]    w_reg;
    logic signed [PW-1:0] prod_reg, acc_reg;

    logic [NW-1:0]      nx, ny;
    logic [KW-1:0]      last_x, last_y, last_ax, addr;
    logic signed [31:0] q_ax, rd_ax;
    logic [33:0]        div_shift;
    logic               div_ge;
    logic [KW-1:0]      ci, cj;
    logic [GAW-1:0]     gaddr, gwaddr;
    logic [FW-1:0]      wa, wb;
    logic               le_first, ge_last, scan_more;

    always_comb
    begin
        if (x_count < 5'd2)
            nx = NW'(2);
        else if (int'(x_count) > MAX_X)
            nx = NW'(MAX_X);
        else
            nx = NW'(x_count);
        if (y_count < 5'd2)
            ny = NW'(2);
        else if (int'(y_count) > MAX_Y)
            ny = NW'(MAX_Y);
        else
            ny = NW'(y_count);
    end

    assign last_x  = KW'(nx - NW'(1));
    assign last_y  = KW'(ny - NW'(1));
    assign last_ax = cmd.axis ? last_y : last_x;
    assign q_ax    = cmd.axis ? qy_reg : qx_reg;
    assign rd_ax   = cmd.axis ? rdy_reg : rdx_reg;

    always_comb
    begin
        unique case (cmd.addr_sel)
            bti_pkg::ADDR_ZERO: addr = '0;
            bti_pkg::ADDR_LAST: addr = last_ax;
            bti_pkg::ADDR_NEXT: addr = k_reg + KW'(1);
            default:            addr = '0;
        endcase
    end

    assign le_first  = q_ax <= rd_ax;
    assign ge_last   = q_ax >= rd_ax;
    assign scan_more = (k_reg < last_ax) && (rd_ax <= q_ax);

    assign div_shift = {rem_reg, 1'b0};
    assign div_ge    = div_shift >= {1'b0, den_reg};

    // corner order: (i,j), (i+1,j), (i,j+1), (i+1,j+1)
    assign ci     = i_reg + KW'(corner_reg[0]);
    assign cj     = j_reg + KW'(corner_reg[1]);
    assign gaddr  = GAW'(int'(ci) * MAX_Y + int'(cj));
    assign gwaddr = GAW'(int'(row_index) * MAX_Y + int'(col_index));
    assign wa     = corner_reg[0] ? fx_reg : bti_pkg::FRAC_ONE - fx_reg;
    assign wb     = corner_reg[1] ? fy_reg : bti_pkg::FRAC_ONE - fy_reg;

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (in_fire && action == bti_pkg::ACT_WRITE_X && int'(row_index) < MAX_X)
            xmem[XAW'(row_index)] <= write_value;
        if (in_fire && action == bti_pkg::ACT_WRITE_Y && int'(col_index) < MAX_Y)
            ymem[YAW'(col_index)] <= write_value;
        if (in_fire && action == bti_pkg::ACT_WRITE_G && int'(row_index) < MAX_X
            && int'(col_index) < MAX_Y)
            gmem[gwaddr] <= write_value;
        rdx_reg <= xmem[addr[XAW-1:0]];
        rdy_reg <= ymem[addr[YAW-1:0]];
        rdg_reg <= gmem[gaddr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bti_pkg::OP_NONE: ;
            bti_pkg::OP_LOAD:
            begin
                qx_reg     <= query_x;
                qy_reg     <= query_y;
                acc_reg    <= '0;
                corner_reg <= '0;
            end
            bti_pkg::OP_FIRST:
            begin
                lo_reg <= rd_ax;
                k_reg  <= '0;
                if (le_first)
                begin
                    if (cmd.axis)
                    begin
                        j_reg  <= '0;
                        fy_reg <= '0;
                    end
                    else
                    begin
                        i_reg  <= '0;
                        fx_reg <= '0;
                    end
                end
            end
            bti_pkg::OP_LAST:
            begin
                k_reg <= k_reg + KW'(1);
                if (ge_last)
                begin
                    if (cmd.axis)
                    begin
                        j_reg  <= last_ax - KW'(1);
                        fy_reg <= bti_pkg::FRAC_ONE;
                    end
                    else
                    begin
                        i_reg  <= last_ax - KW'(1);
                        fx_reg <= bti_pkg::FRAC_ONE;
                    end
                end
            end
            bti_pkg::OP_SCAN:
            begin
                if (scan_more)
                begin
                    lo_reg <= rd_ax;
                    k_reg  <= k_reg + KW'(1);
                end
                else
                begin
                    rem_reg     <= 33'({q_ax[31], q_ax} - {lo_reg[31], lo_reg});
                    den_reg     <= 33'({rd_ax[31], rd_ax} - {lo_reg[31], lo_reg});
                    div_cnt_reg <= '0;
                    if (cmd.axis)
                    begin
                        j_reg  <= k_reg - KW'(1);
                        fy_reg <= '0;
                    end
                    else
                    begin
                        i_reg  <= k_reg - KW'(1);
                        fx_reg <= '0;
                    end
                end
            end
            bti_pkg::OP_DIV:
            begin
                rem_reg     <= div_ge ? 33'(div_shift - {1'b0, den_reg}) : div_shift[32:0];
                div_cnt_reg <= div_cnt_reg + 4'd1;
                if (cmd.axis)
                    fy_reg <= {fy_reg[FW-2:0], div_ge};
                else
                    fx_reg <= {fx_reg[FW-2:0], div_ge};
            end
            bti_pkg::OP_WGT: w_reg <= wa * wb;
            bti_pkg::OP_MUL: prod_reg <= PW'($signed({1'b0, w_reg}) * rdg_reg);
            bti_pkg::OP_ACC:
            begin
                acc_reg    <= acc_reg + prod_reg;
                corner_reg <= corner_reg + 2'd1;
            end
            bti_pkg::OP_OUT: out_reg <= acc_reg[63:32];
            default: ;
        endcase
    end

    assign stat.le_first    = le_first;
    assign stat.ge_last     = ge_last;
    assign stat.scan_more   = scan_more;
    assign stat.div_last    = div_cnt_reg == 4'd15;
    assign stat.corner_last = corner_reg == 2'd3;
    assign interpolated     = out_reg;

endmodule
`default_nettype wire

### rtl/core/bilinear_table_interpolator.sv
// Top level of the bilinear table interpolator: APB count registers,
// controller and datapath. Depends on bti_pkg, bti_ctrl, bti_dp and the macros header.
`default_nettype none
`include "bilinear_table_interpolator_macros.svh"
// Write items (x breakpoint, y breakpoint, grid value) are taken while the
// sequencer is idle and leave it idle. An evaluate transfer runs through a
// sequencer: for each axis, x then y, it reads and tests the end breakpoints,
// then does a linear scan and a restoring divide for the fraction (an axis
// whose query clamps skips both), then four corner multiply-accumulate steps
// of weight, multiply and accumulate. Inputs stall until the result is
// handed to the output register. The breakpoint and grid memories power up
// undefined.
module bilinear_table_interpolator #(
    parameter int MAX_X_POINTS = bti_pkg::MAX_X_POINTS,
    parameter int MAX_Y_POINTS = bti_pkg::MAX_Y_POINTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         row_index,
    input  wire logic [3:0]         col_index,
    input  wire logic signed [31:0] write_value,
    input  wire logic signed [31:0] query_x,
    input  wire logic signed [31:0] query_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      interpolated
);

    logic [4:0] x_count_reg, y_count_reg;
    logic       cfg_we, in_fire;
    bti_pkg::cmd_t  cmd;
    bti_pkg::stat_t stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= 5'd2;
            y_count_reg <= 5'd2;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == bti_pkg::REG_X_COUNT)
                x_count_reg <= pwdata[4:0];
            else
                y_count_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == bti_pkg::REG_X_COUNT) ? {27'd0, x_count_reg}
                                                      : {27'd0, y_count_reg};

    assign in_fire = in_valid && !in_stall;

    bti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bti_dp #(
        .MAX_X (MAX_X_POINTS),
        .MAX_Y (MAX_Y_POINTS)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .in_fire      (in_fire),
        .action       (action),
        .row_index    (row_index),
        .col_index    (col_index),
        .write_value  (write_value),
        .query_x      (query_x),
        .query_y      (query_y),
        .x_count      (x_count_reg),
        .y_count      (y_count_reg),
        .stat         (stat),
        .interpolated (interpolated)
    );

    // an evaluate transfer keeps the input side busy
    `BTI_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && action == bti_pkg::ACT_EVAL, in_stall)
    // a write leaves the input side free for the next item
    `BTI_ASSERT_NEXT(a_write_free, in_valid && !in_stall && action != bti_pkg::ACT_EVAL, !in_stall)
    // a new result only comes out of a running evaluation
    `BTI_ASSERT_NOW(a_out_from_eval, $rose(out_valid), $past(in_stall))

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for bilinear_table_interpolator: loads breakpoint and grid
// tables, sweeps count settings over APB and checks every interpolated result.
// Depends on bti_pkg and the bilinear_table_interpolator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] X_COUNT_ADDR = {bti_pkg::REG_X_COUNT, 2'b00};
    localparam logic [2:0] Y_COUNT_ADDR = {bti_pkg::REG_Y_COUNT, 2'b00};
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 135;

    // Tracks table contents and count registers, predicts interpolated values.
    class interp_scoreboard;
        int x_bp[16];
        int y_bp[16];
        int grid[256];
        int x_cnt = 2;
        int y_cnt = 2;
        int expected_vals[$];
        int errors = 0;
        int evals = 0;
        int writes = 0;

        function int clamp_cnt(int c);
            if (c < 2) return 2;
            if (c > 16) return 16;
            return c;
        endfunction

        function void axis_position(int bp[16], int n, int q, output int idx,
                                    output longint frac);
            int k;
            longint num, den;
            if (q <= bp[0]) begin
                idx = 0;
                frac = 0;
            end else if (q >= bp[n-1]) begin
                idx = n - 2;
                frac = 65536;
            end else begin
                k = 1;
                while (k < n - 1 && bp[k] <= q) k++;
                idx = k - 1;
                num = longint'(q) - longint'(bp[k-1]);
                den = longint'(bp[k]) - longint'(bp[k-1]);
                frac = (den <= 0) ? 0 : (num * 65536) / den;
            end
        endfunction

        function void note_transfer(logic [1:0] act, logic [3:0] row, logic [3:0] col,
                                    int wv, int qx, int qy);
            int i, j;
            longint fx, fy, gx, gy, total;
            case (act)
                bti_pkg::ACT_WRITE_X: begin x_bp[row] = wv; writes++; end
                bti_pkg::ACT_WRITE_Y: begin y_bp[col] = wv; writes++; end
                bti_pkg::ACT_WRITE_G: begin grid[row*16 + col] = wv; writes++; end
                default: begin
                    axis_position(x_bp, clamp_cnt(x_cnt), qx, i, fx);
                    axis_position(y_bp, clamp_cnt(y_cnt), qy, j, fy);
                    gx = 65536 - fx;
                    gy = 65536 - fy;
                    total = gx * gy * longint'(grid[i*16 + j])
                          + fx * gy * longint'(grid[(i+1)*16 + j])
                          + gx * fy * longint'(grid[i*16 + j + 1])
                          + fx * fy * longint'(grid[(i+1)*16 + j + 1]);
                    expected_vals.push_back(int'(total >>> 32));
                    evals++;
                end
            endcase
        endfunction

        function void check_result(int actual);
            int want;
            if (expected_vals.size() == 0) begin
                $error("interpolated: unexpected result %0d", actual);
                errors++;
            end else begin
                want = expected_vals.pop_front();
                if (want != actual) begin
                    $error("interpolated: expected %0d actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = bti_pkg::ACT_WRITE_X;
    logic [3:0] row_index = '0, col_index = '0;
    logic signed [31:0] write_value = '0, query_x = '0, query_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] interpolated;

    interp_scoreboard sb = new();
    int cycles = 0;
    bit no_idle = 0;
    bit hold_req = 0;

    bilinear_table_interpolator dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // input and output monitors
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_transfer(action, row_index, col_index, write_value, query_x, query_y);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(interpolated);
    end

    // receiver: random stall before each result, one long hold-off on request
    initial begin
        int w;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                w = 600;
                hold_req = 0;
            end else
                w = no_idle ? 0 : $urandom_range(0, 9);
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(logic [1:0] act, logic [3:0] row, logic [3:0] col,
                             int wv, int qx, int qy);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= act;
        row_index <= row;
        col_index <= col;
        write_value <= wv;
        query_x <= qx;
        query_y <= qy;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one edge first so the monitor has noted the last transfer
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_vals.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_counts(int xc, int yc);
        wait_idle();
        apb_write(X_COUNT_ADDR, 32'(xc));
        apb_write(Y_COUNT_ADDR, 32'(yc));
        sb.x_cnt = xc;
        sb.y_cnt = yc;
    endtask

    // mode 0: ascending, 1: spans the full range, 2: unordered with repeats
    task automatic load_axes(int mode);
        int start, v;
        for (int ax = 0; ax < 2; ax++) begin
            start = -int'($urandom_range(0, 1 << 22));
            v = start;
            for (int k = 0; k < 16; k++) begin
                if (mode == 1)
                    v = (k == 15) ? 32'h7fffffff : int'(32'h80000000 + k * 32'h1000_0000);
                else if (mode == 2)
                    v = ($urandom_range(0, 3) == 0) ? v : int'($urandom_range(0, 255)) << 12;
                else if (k > 0)
                    v = v + int'($urandom_range(1, ($urandom_range(0, 1)) ? 1 << 20 : 16));
                if (ax == 0)
                    send_item(bti_pkg::ACT_WRITE_X, 4'(k), 4'($urandom), v,
                              $urandom, $urandom);
                else
                    send_item(bti_pkg::ACT_WRITE_Y, 4'($urandom), 4'(k), v,
                              $urandom, $urandom);
            end
        end
    endtask

    function automatic int pick_query(int bp[16], int n);
        longint lo, hi, q;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return bp[$urandom_range(0, 15)];
            2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            default: begin
                lo = longint'(bp[0]) - 70000;
                hi = longint'(bp[sb.clamp_cnt(n) - 1]) + 70000;
                if (hi <= lo) hi = lo + 140000;
                q = lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
                if (q > 64'sh7fffffff) q = 64'sh7fffffff;
                if (q < -64'sh80000000) q = -64'sh80000000;
                return int'(q);
            end
        endcase
    endfunction

    task automatic send_eval(int qx, int qy);
        send_item(bti_pkg::ACT_EVAL, 4'($urandom), 4'($urandom), $urandom, qx, qy);
    endtask

    initial begin
        int xsets[NUM_PHASES] = '{16, 2, 0, 31, 5, 16};
        int ysets[NUM_PHASES] = '{16, 2, 1, 17, 9, 3};
        int gv, r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_counts(16, 16);
        load_axes(0);
        // every grid entry written once so no evaluate touches an unwritten cell
        for (int k = 0; k < 256; k++) begin
            case (k % 7)
                0: gv = 32'h7fffffff;
                1: gv = 32'h80000000;
                default: gv = $urandom;
            endcase
            send_item(bti_pkg::ACT_WRITE_G, 4'(k / 16), 4'(k % 16), gv, $urandom, $urandom);
        end

        // directed: below range, above range, on breakpoints, query extremes
        send_eval(32'h80000000, 32'h80000000);
        send_eval(32'h7fffffff, 32'h7fffffff);
        send_eval(32'h80000000, 32'h7fffffff);
        send_eval(sb.x_bp[0], sb.y_bp[15]);
        send_eval(sb.x_bp[15], sb.y_bp[0]);
        send_eval(sb.x_bp[7], sb.y_bp[8]);
        send_eval(sb.x_bp[3] + 1, sb.y_bp[4] - 1);
        send_eval(sb.x_bp[14] - 1, sb.y_bp[1] + 1);
        send_eval(0, 0);
        send_eval(-1, 1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_counts(xsets[p], ysets[p]);
            if (p == 5)
                set_counts($urandom_range(0, 31), $urandom_range(0, 31));
            load_axes(p == 2 ? 1 : (p == 4 ? 2 : 0));
            no_idle = (p == 1);
            hold_req = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_item(bti_pkg::ACT_WRITE_G, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                else if (r == 1)
                    send_item(bti_pkg::ACT_WRITE_X, $urandom, $urandom,
                              sb.x_bp[$urandom_range(0, 15)] + int'($urandom_range(0, 3)),
                              $urandom, $urandom);
                else if (r == 2)
                    send_item(bti_pkg::ACT_WRITE_Y, $urandom, $urandom,
                              sb.y_bp[$urandom_range(0, 15)] - int'($urandom_range(0, 3)),
                              $urandom, $urandom);
                else
                    send_eval(pick_query(sb.x_bp, sb.x_cnt), pick_query(sb.y_bp, sb.y_cnt));
            end
            no_idle = 0;
        end

        wait_idle();
        $display("Covered %0d evaluations and %0d table writes over %0d count settings,",
                 sb.evals, sb.writes, NUM_PHASES + 2);
        $display("including clamped queries, odd count values and a long output hold-off.");
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
